// ----- hw/rtl/assert_macros.svh -----
// Assertion helper macros for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked at every clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

// ----- hw/rtl/lrusa_pkg.sv -----
// -----------------------------------------------------------------------------
// LRU slot allocator package
// Shared constants and codes for the slot allocator.
// -----------------------------------------------------------------------------
package lrusa_pkg;
    localparam int NUM_SLOTS_DEF   = 8;
    localparam int SPILL_DEPTH_DEF = 64;
    localparam int KEY_BITS_DEF    = 16;
    localparam int SLOT_W          = 3;
    localparam int OUT_KEY_W       = 16;
    localparam int AGE_W           = 8;

    localparam logic       CMD_ALLOC   = 1'b0;
    localparam logic       CMD_FREE    = 1'b1;
    localparam logic [1:0] OUT_HIT     = 2'd0;
    localparam logic [1:0] OUT_RELOAD  = 2'd1;
    localparam logic [1:0] OUT_PLACED  = 2'd2;
    localparam logic [1:0] OUT_FREED   = 2'd3;
    localparam logic [1:0] ERR_NONE    = 2'd0;
    localparam logic [1:0] ERR_UNKNOWN = 2'd1;
    localparam logic [1:0] ERR_FULL    = 2'd2;
endpackage

// ----- hw/rtl/lrusa_ram.sv -----
// -----------------------------------------------------------------------------
// Generic RAM
// Single write port, one registered read port.
// -----------------------------------------------------------------------------
module lrusa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// ----- hw/rtl/lru_register_slot_allocator_unit.sv -----
// -----------------------------------------------------------------------------
// LRU register slot allocator
// Fully associative slot set with an age-based victim and a spill memory.
// -----------------------------------------------------------------------------
// One transfer in at a time. A hit or a free of a slot-resident key is settled
// by the slot check alone; anything that must look in the spill store goes
// through a sequential scan of the spill memory through its single read port,
// which also finds the lowest free spill entry in the same pass. The result
// waits in an output register. Spill valid bits are flip-flops cleared at
// reset, so no clearing pass is needed.
`include "assert_macros.svh"
module lru_register_slot_allocator_unit #(
    parameter int NUM_SLOTS   = lrusa_pkg::NUM_SLOTS_DEF,
    parameter int SPILL_DEPTH = lrusa_pkg::SPILL_DEPTH_DEF,
    parameter int KEY_BITS    = lrusa_pkg::KEY_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,  // var_key[15:0]
    input  logic        s_axis_tuser,  // command
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata   // slot[2:0], outcome[4:3], spilled[5],
                                       // spilled_key[21:6], error[23:22]
);
    localparam int SW  = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int EW  = $clog2(SPILL_DEPTH);
    localparam int CW  = EW + 1;
    localparam int ENW = KEY_BITS + SW;
    localparam logic [lrusa_pkg::AGE_W-1:0] AGE_STEP = {{(lrusa_pkg::AGE_W-1){1'b0}}, 1'b1};

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_SCAN = 3'd1;
    localparam logic [2:0] ST_LAST = 3'd2;
    localparam logic [2:0] ST_DONE = 3'd3;
    localparam logic [2:0] ST_OUT  = 3'd4;

    logic [2:0]          r_state;
    logic                r_cmd;
    logic [KEY_BITS-1:0] r_key;
    logic [NUM_SLOTS-1:0] r_sv;
    logic [KEY_BITS-1:0] r_sk [NUM_SLOTS];
    logic [lrusa_pkg::AGE_W-1:0] r_sa [NUM_SLOTS];
    logic [SPILL_DEPTH-1:0] r_pv;
    logic                r_pv_rd;
    logic [CW-1:0]       r_cnt;
    logic                r_hit_f, r_free_f;
    logic [EW-1:0]       r_hit_e, r_free_e;
    logic [SW-1:0]       r_old;
    logic                r_ovalid;
    logic [23:0]         r_odata;

    logic [ENW-1:0] w_rdata;
    logic           w_we;
    logic [EW-1:0]  w_waddr;
    logic [ENW-1:0] w_wdata;

    lrusa_ram #(.WIDTH(ENW), .DEPTH(SPILL_DEPTH)) u_spill (
        .i_clk(i_clk), .i_we(w_we), .i_waddr(w_waddr), .i_wdata(w_wdata),
        .i_raddr(r_cnt[EW-1:0]), .o_rdata(w_rdata)
    );

    // The spill valid bit is read at the memory address, so it lines up with w_rdata.
    always_ff @(posedge i_clk) begin
        r_pv_rd <= r_pv[r_cnt[EW-1:0]];
    end

    // Slot lookup and victim choice over the small register set.
    logic          w_shit;
    logic [SW-1:0] w_sidx, w_vict;
    logic          w_vempty;
    logic [lrusa_pkg::AGE_W-1:0] w_best;
    always_comb begin
        w_shit = 1'b0; w_sidx = '0;
        for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
            if (r_sv[i] && r_sk[i] == r_key) begin
                w_shit = 1'b1; w_sidx = SW'(i);
            end
        end
        w_vempty = 1'b0; w_vict = '0; w_best = '0;
        for (int i = 0; i < NUM_SLOTS; i++) begin
            if (!w_vempty) begin
                if (!r_sv[i]) begin
                    w_vempty = 1'b1; w_vict = SW'(i);
                end else if (i == 0 || r_sa[i] > w_best) begin
                    w_best = r_sa[i]; w_vict = SW'(i);
                end
            end
        end
    end

    // Scan compare of the previous read address.
    logic [EW-1:0] w_pidx;
    logic          w_match;
    assign w_pidx  = EW'(r_cnt - CW'(1));
    assign w_match = r_pv_rd && w_rdata[KEY_BITS-1:0] == r_key;

    // Final decision in ST_DONE.
    logic [SW-1:0]  w_dslot;
    logic           w_dspill;
    logic [1:0]     w_dout;
    logic           w_old_ok;
    always_comb begin
        w_old_ok = r_hit_f && (NUM_SLOTS == (1 << SW) || 32'(r_old) < NUM_SLOTS)
                   && !r_sv[r_old];
        w_dslot  = w_old_ok ? r_old : w_vict;
        w_dspill = r_sv[w_dslot];
        w_dout   = r_hit_f ? lrusa_pkg::OUT_RELOAD : lrusa_pkg::OUT_PLACED;
    end

    logic w_push_ok;
    logic [EW-1:0] w_push_e;
    always_comb begin
        // A reload frees its entry first, which is then the lowest free one.
        w_push_ok = r_free_f || r_hit_f;
        w_push_e  = (r_hit_f && (!r_free_f || r_hit_e < r_free_e)) ? r_hit_e : r_free_e;
    end

    assign w_we    = (r_state == ST_DONE) && !r_cmd && w_dspill && w_push_ok;
    assign w_waddr = w_push_e;
    assign w_wdata = {w_dslot, r_sk[w_dslot]};

    assign s_axis_tready = (r_state == ST_IDLE) && !r_ovalid;
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;

    function automatic logic [23:0] pack(logic [SW-1:0] s, logic [1:0] o, logic sp,
                                         logic [KEY_BITS-1:0] k, logic [1:0] e);
        logic [23:0] v;
        v = '0;
        v[2:0]   = 3'(s);
        v[4:3]   = o;
        v[5]     = sp;
        v[21:6]  = 16'(k);
        v[23:22] = e;
        return v;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE; r_sv <= '0; r_pv <= '0; r_ovalid <= 1'b0; r_cnt <= '0;
            for (int i = 0; i < NUM_SLOTS; i++) begin
                r_sk[i] <= '0; r_sa[i] <= '0;
            end
        end else begin
            if (r_ovalid && m_axis_tready) r_ovalid <= 1'b0;
            unique case (r_state)
                ST_IDLE: begin
                    if (s_axis_tvalid && s_axis_tready) begin
                        r_cmd <= s_axis_tuser;
                        r_key <= KEY_BITS'(s_axis_tdata);
                        r_state <= ST_OUT;
                        r_cnt <= '0;
                    end
                end
                ST_OUT: begin
                    // Slot check; go to the spill scan on a miss.
                    r_hit_f <= 1'b0; r_free_f <= 1'b0;
                    if (w_shit) begin
                        r_ovalid <= 1'b1; r_state <= ST_IDLE;
                        if (r_cmd == lrusa_pkg::CMD_FREE) begin
                            r_sv[w_sidx] <= 1'b0;
                            r_odata <= pack(w_sidx, lrusa_pkg::OUT_FREED, 1'b0, '0,
                                            lrusa_pkg::ERR_NONE);
                        end else begin
                            for (int i = 0; i < NUM_SLOTS; i++)
                                if (SW'(i) == w_sidx) r_sa[i] <= '0;
                                else if (r_sa[i] != '1) r_sa[i] <= r_sa[i] + AGE_STEP;
                            r_odata <= pack(w_sidx, lrusa_pkg::OUT_HIT, 1'b0, '0,
                                            lrusa_pkg::ERR_NONE);
                        end
                    end else begin
                        r_cnt <= CW'(1); r_state <= ST_SCAN;
                    end
                end
                ST_SCAN, ST_LAST: begin
                    // The last entry is compared in ST_SCAN; ST_LAST only lets the flags settle.
                    if (r_state == ST_SCAN) begin
                        if (w_match && !r_hit_f) begin
                            r_hit_f <= 1'b1; r_hit_e <= w_pidx;
                            r_old <= w_rdata[ENW-1:KEY_BITS];
                        end
                        if (!r_pv_rd && !r_free_f) begin
                            r_free_f <= 1'b1; r_free_e <= w_pidx;
                        end
                    end
                    if (r_state == ST_LAST) r_state <= ST_DONE;
                    else begin
                        if (r_cnt == CW'(SPILL_DEPTH)) r_state <= ST_LAST;
                        else r_cnt <= r_cnt + CW'(1);
                    end
                    if (r_cnt == CW'(SPILL_DEPTH)) r_cnt <= '0;
                end
                ST_DONE: begin
                    r_ovalid <= 1'b1; r_state <= ST_IDLE;
                    if (r_cmd == lrusa_pkg::CMD_FREE) begin
                        if (r_hit_f) r_pv[r_hit_e] <= 1'b0;
                        r_odata <= pack('0, lrusa_pkg::OUT_FREED, 1'b0, '0,
                                        r_hit_f ? lrusa_pkg::ERR_NONE : lrusa_pkg::ERR_UNKNOWN);
                    end else begin
                        // When the victim reuses the reloaded entry, the entry stays valid.
                        if (r_hit_f && !(w_we && w_push_e == r_hit_e)) r_pv[r_hit_e] <= 1'b0;
                        if (w_we) r_pv[w_push_e] <= 1'b1;
                        r_sv[w_dslot] <= 1'b1;
                        r_sk[w_dslot] <= r_key;
                        for (int i = 0; i < NUM_SLOTS; i++)
                            if (SW'(i) == w_dslot) r_sa[i] <= '0;
                            else if (r_sa[i] != '1) r_sa[i] <= r_sa[i] + AGE_STEP;
                        r_odata <= pack(w_dslot, w_dout, w_dspill,
                                        w_dspill ? r_sk[w_dslot] : '0,
                                        (w_dspill && !w_push_ok) ? lrusa_pkg::ERR_FULL
                                                                 : lrusa_pkg::ERR_NONE);
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    `ASSERT_IMPL(a_busy_not_ready, i_clk, i_rst_n, r_state != ST_IDLE, !s_axis_tready)
    `ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready, r_state == ST_OUT)
    `ASSERT_IMPL(a_push_needs_victim, i_clk, i_rst_n, w_we, !r_cmd && r_sv[w_dslot])
endmodule
